/* sv/plsm_pkg.sv */
// ----------------------------------------------------------------------------
// plsm_pkg
// Shared types and constants of the PID line steering mixer.
// ----------------------------------------------------------------------------
package plsm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_GAIN   = 3'd0,
    CFG_KI_GAIN   = 3'd1,
    CFG_KD_GAIN   = 3'd2,
    CFG_GOAL_POS  = 3'd3,
    CFG_MIN_DUTY  = 3'd4,
    CFG_MAX_DUTY  = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] KP_GAIN_RST  = 16'd5280;
  localparam logic [15:0] KI_GAIN_RST  = 16'd8;
  localparam logic [15:0] KD_GAIN_RST  = 16'd1728;
  localparam logic [10:0] GOAL_POS_RST = 11'd512;
  localparam logic [15:0] MIN_DUTY_RST = 16'd0;
  localparam logic [15:0] MAX_DUTY_RST = 16'd1000;

  // saturation bounds of the running error sum and the steering value
  localparam logic signed [23:0] SUM_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] SUM_MIN   = -24'sh800000;
  localparam logic signed [16:0] STEER_MAX = 17'sh0FFFF;
  localparam logic signed [16:0] STEER_MIN = -17'sh10000;

endpackage

/* sv/pid_line_steering_mixer_unit.sv */
// ----------------------------------------------------------------------------
// pid_line_steering_mixer_unit
// PID steering from line-position samples, mixed into two wheel duties.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per control tick, a Q3.8 line position or a lost mark.
//   out_* : one item per input item: stop flag, steering value, two duties.
//   cfg_* : register writes (index, data); always ready, write only when idle.
// Path: an accepted item lands in the input register; once the output register
//   is free or being taken, its result is loaded there and out_valid rises.
// Throughput: one item per cycle while out_ready stays high, set by the single
//   compute pass between the input and output registers (three multiplies, a
//   sum, saturate and mix).
// The error history (last error, running sum) is updated at the edge the
//   result is loaded (not for a lost line), so the next item sees it right away.
// Stall: while out_ready is low the result holds; one more item can wait in
//   the input register, after that in_ready drops.
// Reset: registers return to their default gains and limits, error history
//   clears, both pipeline stages empty.
// ----------------------------------------------------------------------------
module pid_line_steering_mixer_unit
  import plsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [10:0]         in_line_position,
  input  logic                in_line_lost,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_stop_motors,
  output logic signed [16:0]  out_steer_value,
  output logic [15:0]         out_first_duty,
  output logic [15:0]         out_second_duty,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic [15:0] kp_r, ki_r, kd_r, min_duty_r, max_duty_r;
  logic [10:0] goal_r;

  // error history
  logic signed [11:0] last_err_r;
  logic signed [23:0] sum_r;

  // input stage
  logic        s1_valid_r;
  logic [10:0] pos_r;
  logic        lost_r;

  // output stage
  logic               out_valid_r;
  logic               stop_r;
  logic signed [16:0] steer_r;
  logic [15:0]        first_r, second_r;

  logic advance;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- compute
  logic signed [11:0] err;
  logic signed [12:0] deriv;
  logic signed [24:0] sum_wide;
  logic signed [23:0] sum_nxt;
  logic signed [28:0] p_prod;
  logic signed [40:0] i_prod;
  logic signed [29:0] d_prod;
  logic signed [42:0] acc;
  logic signed [30:0] steer_full;
  logic signed [16:0] steer_nxt;
  logic [16:0]        mag;
  logic signed [17:0] duty_raw;
  logic signed [17:0] duty_lo;
  logic [15:0]        steered;
  logic [15:0]        first_nxt, second_nxt;

  always_comb begin
    err      = $signed({1'b0, goal_r}) - $signed({1'b0, pos_r});
    deriv    = 13'(err) - 13'(last_err_r);
    sum_wide = 25'(sum_r) + 25'(err);
    // saturate when the top two bits disagree
    if (sum_wide[24] != sum_wide[23]) begin
      sum_nxt = sum_wide[24] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[23:0];
    end

    p_prod = 29'($signed({1'b0, kp_r})) * 29'(err);
    i_prod = 41'($signed({1'b0, ki_r})) * 41'(sum_nxt);
    d_prod = 30'($signed({1'b0, kd_r})) * 30'(deriv);
    acc    = 43'(p_prod) + 43'(i_prod) + 43'(d_prod);

    // dropping 12 fraction bits of a signed value rounds toward minus infinity
    steer_full = acc[42:12];
    if (steer_full[30:16] != {15{steer_full[30]}}) begin
      steer_nxt = steer_full[30] ? STEER_MIN : STEER_MAX;
    end else begin
      steer_nxt = steer_full[16:0];
    end

    mag      = steer_nxt[16] ? 17'(-steer_nxt) : 17'(steer_nxt);
    duty_raw = $signed({2'b00, max_duty_r}) - $signed({1'b0, mag});
    // min clamp first, then max, so min above max ends at max
    if (duty_raw < $signed({2'b00, min_duty_r})) begin
      duty_lo = $signed({2'b00, min_duty_r});
    end else begin
      duty_lo = duty_raw;
    end
    if (duty_lo > $signed({2'b00, max_duty_r})) begin
      steered = max_duty_r;
    end else begin
      steered = duty_lo[15:0];
    end

    // negative error steers the right wheel
    if (err[11]) begin
      first_nxt  = steered;
      second_nxt = max_duty_r;
    end else begin
      first_nxt  = max_duty_r;
      second_nxt = steered;
    end
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= KP_GAIN_RST;
      ki_r        <= KI_GAIN_RST;
      kd_r        <= KD_GAIN_RST;
      goal_r      <= GOAL_POS_RST;
      min_duty_r  <= MIN_DUTY_RST;
      max_duty_r  <= MAX_DUTY_RST;
      last_err_r  <= '0;
      sum_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KP_GAIN:  kp_r       <= cfg_data;
          CFG_KI_GAIN:  ki_r       <= cfg_data;
          CFG_KD_GAIN:  kd_r       <= cfg_data;
          CFG_GOAL_POS: goal_r     <= cfg_data[10:0];
          CFG_MIN_DUTY: min_duty_r <= cfg_data;
          CFG_MAX_DUTY: max_duty_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end

      if (advance) begin
        out_valid_r <= 1'b1;
        // a lost line leaves the history untouched
        if (!lost_r) begin
          last_err_r <= err;
          sum_r      <= sum_nxt;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_r  <= in_line_position;
      lost_r <= in_line_lost;
    end
    if (advance) begin
      stop_r <= lost_r;
      if (lost_r) begin
        steer_r  <= '0;
        first_r  <= '0;
        second_r <= '0;
      end else begin
        steer_r  <= steer_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stop_motors = stop_r;
  assign out_steer_value = steer_r;
  assign out_first_duty  = first_r;
  assign out_second_duty = second_r;

endmodule

/* tb/sv/pid_line_steering_mixer_unit_tb.sv */
// ----------------------------------------------------------------------------
// pid_line_steering_mixer_unit_tb
// Self-checking bench for the PID line steering mixer.
// Drives line samples and lost marks through the valid/ready input, writes
// gains, goal and duty limits between phases, and checks every result item
// against an in-bench model of the PID, its saturations and the wheel mixer.
// ----------------------------------------------------------------------------
module pid_line_steering_mixer_unit_tb;
  import plsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RST_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES = 48;   // long receiver hold-off
  localparam int unsigned SETTLE      = 4;    // cycles waited after drain
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 245;

  // indexes past the register list; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  // one result item as the block should deliver it
  typedef struct {
    logic               stop;
    logic signed [16:0] steer;
    logic [15:0]        first;
    logic [15:0]        second;
  } steer_result_t;

  // --------------------------------------------------------------------------
  // Steering tracker: mirrors registers and error history, predicts each
  // result at input acceptance and checks results in order.
  // --------------------------------------------------------------------------
  class steer_tracker;
    logic [15:0]        kp, ki, kd, min_duty, max_duty;
    logic [10:0]        goal;
    logic signed [11:0] last_err;
    logic signed [23:0] err_sum;
    steer_result_t      pending[$];
    int unsigned n_checked, n_mismatch, n_unexpected;
    int unsigned n_lost, n_right, n_left, n_sum_hi, n_sum_lo, n_steer_sat, n_inverted;

    function new();
      kp       = KP_GAIN_RST;
      ki       = KI_GAIN_RST;
      kd       = KD_GAIN_RST;
      goal     = GOAL_POS_RST;
      min_duty = MIN_DUTY_RST;
      max_duty = MAX_DUTY_RST;
      last_err = '0;
      err_sum  = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_KP_GAIN:  kp       = data;
        CFG_KI_GAIN:  ki       = data;
        CFG_KD_GAIN:  kd       = data;
        CFG_GOAL_POS: goal     = data[10:0];
        CFG_MIN_DUTY: min_duty = data;
        CFG_MAX_DUTY: max_duty = data;
        default: ;
      endcase
    endfunction

    function void predict_steering(logic [10:0] pos, logic lost);
      longint err, diff, sum, acc, st, mag, duty;
      steer_result_t r;
      if (lost) begin
        // line lost: stop, zero outputs, history untouched
        r.stop   = 1'b1;
        r.steer  = '0;
        r.first  = '0;
        r.second = '0;
        n_lost++;
      end else begin
        err  = longint'(goal) - longint'(pos);
        diff = err - longint'(last_err);
        sum  = longint'(err_sum) + err;
        if (sum > longint'(SUM_MAX)) begin
          sum = longint'(SUM_MAX);
          n_sum_hi++;
        end else if (sum < longint'(SUM_MIN)) begin
          sum = longint'(SUM_MIN);
          n_sum_lo++;
        end
        err_sum  = sum[23:0];
        last_err = err[11:0];
        acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * diff;
        st  = acc >>> 12;   // Q.12 to whole duty units, floor
        if (st > longint'(STEER_MAX)) begin
          st = longint'(STEER_MAX);
          n_steer_sat++;
        end else if (st < longint'(STEER_MIN)) begin
          st = longint'(STEER_MIN);
          n_steer_sat++;
        end
        mag  = (st < 0) ? -st : st;
        duty = longint'(max_duty) - mag;
        if (duty < longint'(min_duty)) duty = longint'(min_duty);
        if (duty > longint'(max_duty)) duty = longint'(max_duty);
        if (min_duty > max_duty) n_inverted++;
        r.stop  = 1'b0;
        r.steer = st[16:0];
        if (err < 0) begin
          r.first  = duty[15:0];
          r.second = max_duty;
          n_right++;
        end else begin
          r.first  = max_duty;
          r.second = duty[15:0];
          n_left++;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic stop, logic signed [16:0] steer,
                               logic [15:0] first, logic [15:0] second);
      steer_result_t exp_r;
      if (pending.size() == 0) begin
        n_unexpected++;
        if (n_mismatch + n_unexpected <= 10)
          $display("ERROR: unexpected result stop=%0b steer=%0d first=%0d second=%0d",
                   stop, steer, first, second);
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (stop !== exp_r.stop || steer !== exp_r.steer ||
          first !== exp_r.first || second !== exp_r.second) begin
        n_mismatch++;
        if (n_mismatch + n_unexpected <= 10)
          $display("ERROR: result %0d exp stop/steer/first/second %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                   n_checked, exp_r.stop, exp_r.steer, exp_r.first, exp_r.second,
                   stop, steer, first, second);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; everything starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [10:0]         in_line_position = '0;
  logic                in_line_lost     = 1'b0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic                out_stop_motors;
  logic signed [16:0]  out_steer_value;
  logic [15:0]         out_first_duty;
  logic [15:0]         out_second_duty;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index        = '0;
  logic [CfgDataW-1:0] cfg_data         = '0;

  // idling switches and the hold-off request, owned by the main sequence
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_req   = 1'b0;
  int unsigned n_holds = 0;

  steer_tracker sb;

  always #(CLK_PERIOD / 2) clk = ~clk;

  pid_line_steering_mixer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_position (in_line_position),
    .in_line_lost     (in_line_lost),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_stop_motors  (out_stop_motors),
    .out_steer_value  (out_steer_value),
    .out_first_duty   (out_first_duty),
    .out_second_duty  (out_second_duty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitors. They sample at the rising edge, so they see the values that
  // were stable before it: exactly what the block saw for the handshake.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.predict_steering(in_line_position, in_line_lost);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_stop_motors, out_steer_value, out_first_duty, out_second_duty);
  end

  // --------------------------------------------------------------------------
  // Result sink. One nonblocking write of out_ready per edge reached. A hold
  // request parks ready low for a long stretch so the two pipeline stages
  // fill up and in_ready drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 4);
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one item and wait for it to be taken. An optional idle burst goes
  // first; when there is none, valid simply stays high for the new item.
  task automatic send_sample(input logic [10:0] pos, input logic lost);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_line_position <= pos;
    in_line_lost     <= lost;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering, let every expected result arrive, then settle. One edge
  // first, so the monitor has noted the last accepted item.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [10:0] goal,
                            input logic [15:0] mn, input logic [15:0] mx);
    write_reg(CFG_KP_GAIN, kp);
    write_reg(CFG_KI_GAIN, ki);
    write_reg(CFG_KD_GAIN, kd);
    write_reg(CFG_GOAL_POS, {5'd0, goal});
    write_reg(CFG_MIN_DUTY, mn);
    write_reg(CFG_MAX_DUTY, mx);
  endtask

  // mostly moderate gains so the steering stays out of saturation often
  function automatic logic [15:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8000));
  endfunction

  task automatic random_config();
    logic [15:0] mx, mn;
    logic [10:0] goal;
    mx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(200, 4000));
    mn = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, mx / 2));
    goal = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
    set_config(pick_gain(), pick_gain(), pick_gain(), goal, mn, mx);
    // spare indexes with junk data must not disturb anything
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'($urandom));
  endtask

  // mix of full-range, sensor-range and near-goal positions
  function automatic logic [10:0] pick_position();
    case ($urandom_range(0, 9))
      0, 1, 2: return 11'($urandom);
      3:       return 11'(sb.goal + $urandom_range(0, 16) - 8);
      default: return 11'($urandom_range(0, 1024));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Timeout
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned errors;
    sb = new();

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset defaults first, no register writes yet.
    send_sample(11'd512, 1'b0);    // zero error, left wheel branch
    send_sample(11'd0, 1'b0);      // positive error
    send_sample(11'd1024, 1'b0);   // negative error, right wheel steered
    send_sample(11'd2047, 1'b0);   // position beyond the sensor range
    send_sample(11'd2047, 1'b1);   // line lost: stop, history kept
    send_sample(11'd768, 1'b0);
    send_sample(11'd0, 1'b1);
    send_sample(11'd256, 1'b0);
    drain();

    // Directed: every gain, the goal and max duty at the top, min duty zero, widest errors.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd2047, 16'd0, 16'hFFFF);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0000);
    send_sample(11'd0, 1'b0);      // error +2047
    send_sample(11'd2047, 1'b0);   // zero error after a large one
    send_sample(11'd0, 1'b0);
    send_sample(11'd1024, 1'b1);
    send_sample(11'd1024, 1'b0);
    drain();

    // Directed: min duty above max duty, steered wheel ends at max duty.
    set_config(16'd5280, 16'd8, 16'd1728, 11'd1024, 16'd2000, 16'd500);
    send_sample(11'd0, 1'b0);
    send_sample(11'd2047, 1'b0);
    send_sample(11'd1024, 1'b0);
    drain();

    // Directed: all zero, goal at zero, largest negative error.
    set_config(16'd0, 16'd0, 16'd0, 11'd0, 16'd0, 16'd0);
    send_sample(11'd2047, 1'b0);
    send_sample(11'd0, 1'b0);
    send_sample(11'd1, 1'b0);
    drain();

    // Random phases: fresh registers each time, the first at defaults,
    // one with the long hold-off and the last without any idling.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        set_config(KP_GAIN_RST, KI_GAIN_RST, KD_GAIN_RST, GOAL_POS_RST,
                   MIN_DUTY_RST, MAX_DUTY_RST);
      else
        random_config();
      tx_idle_en = (p != RAND_PHASES - 1);
      rx_idle_en = (p != RAND_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;
        send_sample(pick_position(), $urandom_range(0, 99) < 8);
      end
      drain();
    end

    errors = sb.n_mismatch + sb.n_unexpected + sb.pending.size();
    $display("Run: %0d results checked, %0d lost marks, %0d left / %0d right steers, %0d holds",
             sb.n_checked, sb.n_lost, sb.n_left, sb.n_right, n_holds);
    $display("Run: sum clamped %0d high / %0d low, steer clamped %0d, inverted limits %0d",
             sb.n_sum_hi, sb.n_sum_lo, sb.n_steer_sat, sb.n_inverted);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
